// ----- hdl/kwrm_pkg.sv -----
// Shared types and constants of the k-way run merger.
package kwrm_pkg;

    localparam int RUN_W   = 4;
    localparam int VALUE_W = 32;
    localparam int CFG_W   = 5;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT
    } kwrm_state_t;

    typedef struct packed {
        logic                      en;
        logic                      clear;
        logic [RUN_W-1:0]          run;
        logic signed [VALUE_W-1:0] value;
        logic                      done;
    } kwrm_wr_t;

    typedef struct packed {
        logic                      done;
        logic                      found;
        logic [RUN_W-1:0]          best_run;
        logic signed [VALUE_W-1:0] best_value;
    } kwrm_scan_t;

endpackage

// ----- hdl/kwrm_ifs.sv -----
// Valid/ready channel interfaces for items, results and configuration.
interface kwrm_item_if;
    import kwrm_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [RUN_W-1:0]          run_index;
    logic signed [VALUE_W-1:0] value;
    logic                      run_done;
    modport source (output valid, run_index, value, run_done, input ready);
    modport sink (input valid, run_index, value, run_done, output ready);
endinterface

interface kwrm_result_if;
    import kwrm_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] merged_value;
    logic [RUN_W-1:0]          source_run;
    logic                      all_done;
    logic                      order_error;
    modport source (output valid, merged_value, source_run, all_done, order_error,
                    input ready);
    modport sink (input valid, merged_value, source_run, all_done, order_error,
                  output ready);
endinterface

interface kwrm_cfg_if;
    import kwrm_pkg::*;
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] runs_in_use;
    modport source (output valid, runs_in_use, input ready);
    modport sink (input valid, runs_in_use, output ready);
endinterface

// ----- hdl/kwrm_heads.sv -----
// Head storage: per-run values, active flags and loading marks.
module kwrm_heads #(
    parameter int DEPTH = 16,
    localparam int IW = $clog2(DEPTH)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  kwrm_pkg::kwrm_wr_t                 wr,
    input  logic [kwrm_pkg::RUN_W-1:0]         query_run,
    output logic                               query_present,
    input  logic [IW-1:0]                      rd_addr,
    output logic signed [kwrm_pkg::VALUE_W-1:0] rd_value,
    output logic                               rd_active
);
    import kwrm_pkg::*;

    logic signed [VALUE_W-1:0] head_value_reg [DEPTH];
    logic [DEPTH-1:0]          active_reg;
    logic [DEPTH-1:0]          present_reg;
    logic [IW-1:0]             waddr;

    assign waddr         = wr.run[IW-1:0];
    assign query_present = present_reg[query_run[IW-1:0]];
    assign rd_value      = head_value_reg[rd_addr];
    assign rd_active     = active_reg[rd_addr];

    always_ff @(posedge clk)
    begin
        if (wr.en && !wr.done)
        begin
            head_value_reg[waddr] <= wr.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= '0;
            present_reg <= '0;
        end
        else if (wr.clear)
        begin
            active_reg  <= '0;
            present_reg <= '0;
        end
        else if (wr.en)
        begin
            active_reg[waddr]  <= !wr.done;
            present_reg[waddr] <= 1'b1;
        end
    end

endmodule

// ----- hdl/kwrm_min_scan.sv -----
// Sequential minimum search over the stored heads with one comparator.
module kwrm_min_scan #(
    parameter int DEPTH = 16,
    localparam int IW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [CW-1:0]                       n,
    output logic [IW-1:0]                       rd_addr,
    input  logic signed [kwrm_pkg::VALUE_W-1:0] rd_value,
    input  logic                                rd_active,
    output kwrm_pkg::kwrm_scan_t                res
);
    import kwrm_pkg::*;

    logic [IW-1:0]             cnt_reg;
    logic                      running_reg;
    logic                      done_reg;
    logic                      found_reg;
    logic [IW-1:0]             best_idx_reg;
    logic signed [VALUE_W-1:0] best_val_reg;
    logic                      take;
    logic                      last;

    assign rd_addr = cnt_reg;
    assign take    = rd_active && (!found_reg || (rd_value < best_val_reg));
    assign last    = (CW'(cnt_reg) == (n - CW'(1)));

    assign res.done       = done_reg;
    assign res.found      = found_reg;
    assign res.best_run   = RUN_W'(best_idx_reg);
    assign res.best_value = best_val_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
            found_reg   <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg     <= '0;
            running_reg <= 1'b1;
            done_reg    <= 1'b0;
            found_reg   <= 1'b0;
        end
        else if (running_reg)
        begin
            if (take)
            begin
                found_reg <= 1'b1;
            end
            if (last)
            begin
                running_reg <= 1'b0;
                done_reg    <= 1'b1;
            end
            else
            begin
                cnt_reg <= cnt_reg + IW'(1);
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (running_reg && !start && take)
        begin
            best_idx_reg <= cnt_reg;
            best_val_reg <= rd_value;
        end
    end

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg |-> (CW'(cnt_reg) < n))
        else $error("scan index beyond run count");

endmodule

// ----- hdl/k_way_run_merger_unit.sv -----
// Top level of the k-way run merger.
//
//  channel   dir   handshake        payload
//  items     in    valid / ready    run_index, value, run_done
//  merged    out   valid / ready    merged_value, source_run, all_done, order_error
//  cfg       in    valid / ready    runs_in_use
//
// An item that completes loading or refills the expected run is accepted, then the
// comparator walks the heads of the n runs in use, n being the run count; the scan
// finishes and the result register is loaded. Other items finish when accepted.
// Reset clears control flags and counters and sets n to DEPTH; head values and result payload are written before use.
// A waiting result blocks new items and configuration until merged.ready takes it.
module k_way_run_merger_unit #(
    parameter int MAX_RUNS = 16
) (
    input logic          clk,
    input logic          rst_n,
    kwrm_item_if.sink    items,
    kwrm_result_if.source merged,
    kwrm_cfg_if.sink     cfg
);
    import kwrm_pkg::*;

    localparam int DEPTH = (MAX_RUNS < 16) ? MAX_RUNS : 16;
    localparam int IW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    kwrm_state_t               state_reg, state_next;
    logic [CW-1:0]             n_reg, n_next;
    logic [CW-1:0]             loaded_reg, loaded_next;
    logic [RUN_W-1:0]          waiting_reg, waiting_next;
    logic                      finished_reg, finished_next;
    logic                      out_valid_reg, out_valid_next;
    logic signed [VALUE_W-1:0] out_value_reg, out_value_next;
    logic [RUN_W-1:0]          out_run_reg, out_run_next;
    logic                      out_done_reg, out_done_next;
    logic                      out_error_reg, out_error_next;

    kwrm_wr_t                  wr;
    kwrm_scan_t                scan_res;
    logic                      scan_start;
    logic                      query_present;
    logic [IW-1:0]             rd_addr;
    logic signed [VALUE_W-1:0] rd_value;
    logic                      rd_active;
    logic                      out_free;
    logic                      item_acc;
    logic                      cfg_acc;
    logic                      idx_ok;
    logic                      loading;

    kwrm_heads #(.DEPTH(DEPTH)) u_heads (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr            (wr),
        .query_run     (items.run_index),
        .query_present (query_present),
        .rd_addr       (rd_addr),
        .rd_value      (rd_value),
        .rd_active     (rd_active)
    );

    kwrm_min_scan #(.DEPTH(DEPTH)) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (scan_start),
        .n         (n_reg),
        .rd_addr   (rd_addr),
        .rd_value  (rd_value),
        .rd_active (rd_active),
        .res       (scan_res)
    );

    assign out_free    = !out_valid_reg || merged.ready;
    assign items.ready = (state_reg == S_IDLE) && out_free && !cfg.valid;
    assign cfg.ready   = (state_reg == S_IDLE) && !out_valid_reg;
    assign item_acc    = items.valid && items.ready;
    assign cfg_acc     = cfg.valid && cfg.ready;
    assign idx_ok      = {1'b0, items.run_index} < 5'(n_reg);
    assign loading     = 5'(loaded_reg) < 5'(n_reg);

    assign merged.valid        = out_valid_reg;
    assign merged.merged_value = out_value_reg;
    assign merged.source_run   = out_run_reg;
    assign merged.all_done     = out_done_reg;
    assign merged.order_error  = out_error_reg;

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        loaded_next    = loaded_reg;
        waiting_next   = waiting_reg;
        finished_next  = finished_reg;
        out_valid_next = out_valid_reg && !merged.ready;
        out_value_next = out_value_reg;
        out_run_next   = out_run_reg;
        out_done_next  = out_done_reg;
        out_error_next = out_error_reg;
        scan_start     = 1'b0;
        wr.en          = 1'b0;
        wr.clear       = 1'b0;
        wr.run         = items.run_index;
        wr.value       = items.value;
        wr.done        = items.run_done;

        case (state_reg)
            S_IDLE:
            begin
                if (cfg_acc)
                begin
                    if (cfg.runs_in_use == '0)
                    begin
                        n_next = CW'(1);
                    end
                    else if (cfg.runs_in_use > CFG_W'(DEPTH))
                    begin
                        n_next = CW'(DEPTH);
                    end
                    else
                    begin
                        n_next = CW'(cfg.runs_in_use);
                    end
                    wr.clear      = 1'b1;
                    loaded_next   = '0;
                    waiting_next  = '0;
                    finished_next = 1'b0;
                end
                else if (item_acc)
                begin
                    if (finished_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_value_next = '0;
                        out_run_next   = '0;
                        out_done_next  = 1'b1;
                        out_error_next = 1'b1;
                    end
                    else if (loading)
                    begin
                        if (!idx_ok || query_present)
                        begin
                            out_valid_next = 1'b1;
                            out_value_next = '0;
                            out_run_next   = '0;
                            out_done_next  = 1'b0;
                            out_error_next = 1'b1;
                        end
                        else
                        begin
                            wr.en       = 1'b1;
                            loaded_next = loaded_reg + CW'(1);
                            if (loaded_next == n_reg)
                            begin
                                scan_start = 1'b1;
                                state_next = S_SCAN;
                            end
                        end
                    end
                    else if ((items.run_index != waiting_reg) || !idx_ok)
                    begin
                        out_valid_next = 1'b1;
                        out_value_next = '0;
                        out_run_next   = waiting_reg;
                        out_done_next  = 1'b0;
                        out_error_next = 1'b1;
                    end
                    else
                    begin
                        wr.en      = 1'b1;
                        scan_start = 1'b1;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_res.done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_error_next = 1'b0;
                    if (scan_res.found)
                    begin
                        waiting_next   = scan_res.best_run;
                        out_value_next = scan_res.best_value;
                        out_run_next   = scan_res.best_run;
                        out_done_next  = 1'b0;
                    end
                    else
                    begin
                        finished_next  = 1'b1;
                        out_value_next = '0;
                        out_run_next   = '0;
                        out_done_next  = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            n_reg         <= CW'(DEPTH);
            loaded_reg    <= '0;
            waiting_reg   <= '0;
            finished_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            loaded_reg    <= loaded_next;
            waiting_reg   <= waiting_next;
            finished_reg  <= finished_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
        out_run_reg   <= out_run_next;
        out_done_reg  <= out_done_next;
        out_error_reg <= out_error_next;
    end

    a_scan_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        scan_res.done |-> (state_reg == S_SCAN))
        else $error("scan finished outside scan state");

    a_loaded_bound: assert property (@(posedge clk) disable iff (!rst_n)
        loaded_reg <= n_reg)
        else $error("more heads loaded than runs in use");

    a_source_is_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_done_reg && !out_error_reg) |->
            (out_run_reg == waiting_reg))
        else $error("emitted run differs from expected refill run");

endmodule
